>>> hw/rtl/cpdt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the constant pool dedup table.
// No dependencies; used by cpdt_ctrl, cpdt_datapath and the top level.
package cpdt_pkg;

  localparam int WORD_W      = 32;
  localparam int WORDS       = 4;
  localparam int IN_DATA_W   = 192;
  localparam int OP_W        = 2;
  localparam int OUT_IDX_W   = 6;
  localparam int OUT_DATA_W  = 16;
  localparam logic [2:0] FULL_SIZE = 3'd4;

  localparam logic KIND_IMMEDIATE = 1'b0;
  localparam logic KIND_STATE     = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_STATE  = 2'd0,
    OP_VEC4   = 2'd1,
    OP_SCALAR = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [WORDS-1:0][WORD_W-1:0] words;
    logic [2:0]                   used;
    logic                         kind;
  } entry_row_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
  } status_t;

  function automatic logic float_is_nan(input logic [WORD_W-1:0] v);
    return v[WORD_W-2:0] > 31'h7f80_0000;
  endfunction

  // IEEE equality: signed zeros are equal, NaN never matches
  function automatic logic float_equal(input logic [WORD_W-1:0] a,
                                       input logic [WORD_W-1:0] b);
    logic zero_pair;
    zero_pair = ((a | b) & 32'h7fff_ffff) == 32'h0;
    if (float_is_nan(a) || float_is_nan(b)) begin
      return 1'b0;
    end
    return zero_pair || (a == b);
  endfunction

endpackage

>>> hw/rtl/constant_pool_dedup_table.sv
`timescale 1ns / 1ps
// Deduplicating constant pool: table of up to DEPTH four-word entries.
// Depends on cpdt_pkg, cpdt_ctrl and cpdt_datapath.
//
// Usage:
//   Slave channel (s_tvalid/s_tready): one request per beat; s_tuser holds
//   the operation (add state pair, add vec4, add scalar, clear), s_tdata the
//   state words and the four float32 values.
//   Master channel (m_tvalid/m_tready): exactly one result beat per request
//   with the entry index, scalar component, found flag and table-full flag.
//   Timing: the entries in use are read one per cycle from the entry memory
//   (one registered read port) until a match or the last entry in use, so a
//   hit stops early. One request is worked on at a time and the next beat is
//   taken the cycle after the result is registered.
//   The result sits in an output register; the next request is taken while
//   it waits. If the receiver stalls, a finished request holds until the
//   output register is free and no further request is taken meanwhile.
//   Reset empties the table and drops any pending result.
module constant_pool_dedup_table #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // state_first, state_second, value_x, value_y, value_z, value_w
  input  logic [191:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_index, smear_component, was_found, table_full, zero fill
  output logic [15:0]  m_tdata
);

  cpdt_pkg::cmd_t    cmd;
  cpdt_pkg::status_t st;

  cpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cpdt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule

>>> hw/rtl/cpdt_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, table scan and commit, owns both handshakes.
// Depends on cpdt_pkg.
module cpdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  cpdt_pkg::status_t st,
  output cpdt_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit || st.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("commit while output register held");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SCAN))
    else $error("accepted beat did not start a scan");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (m_tvalid && state == ST_IDLE))
    else $error("commit did not present a result");

endmodule

>>> hw/rtl/cpdt_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry memory, scan pointer, match logic and result register.
// Depends on cpdt_pkg; driven by cpdt_ctrl commands.
module cpdt_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cpdt_pkg::cmd_t                      cmd,
  output cpdt_pkg::status_t                   st,
  input  logic [cpdt_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [cpdt_pkg::OP_W-1:0]           s_tuser,
  output logic [cpdt_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cpdt_pkg::entry_row_t mem [DEPTH];
  cpdt_pkg::entry_row_t rdata;

  cpdt_pkg::op_t                                   op;
  logic [cpdt_pkg::WORDS-1:0][cpdt_pkg::WORD_W-1:0] req_w;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_addr;
  logic          pend_valid;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [1:0]    found_comp;
  logic          free_valid;
  logic [IW-1:0] free_idx;
  cpdt_pkg::entry_row_t free_row;

  logic [cpdt_pkg::WORDS-1:0] comp_eq;
  logic                       hit;
  logic [1:0]                 hit_comp;
  logic                       is_clear;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  cpdt_pkg::entry_row_t wr_row;
  logic [CW-1:0]        count_next;
  logic [IW-1:0]        res_idx;
  logic [1:0]           res_comp;
  logic                 res_found;
  logic                 res_full;

  assign is_clear = (op == cpdt_pkg::OP_CLEAR);

  always_comb begin
    for (int k = 0; k < cpdt_pkg::WORDS; k++) begin
      comp_eq[k] = cpdt_pkg::float_equal(rdata.words[k], req_w[0]) &&
                   (3'(k) < rdata.used);
    end
    hit_comp = 2'd0;
    for (int k = cpdt_pkg::WORDS - 1; k >= 0; k--) begin
      if (comp_eq[k]) begin
        hit_comp = 2'(k);
      end
    end
    hit = 1'b0;
    case (op)
      cpdt_pkg::OP_STATE: begin
        hit = (rdata.kind == cpdt_pkg::KIND_STATE) &&
              (rdata.words[0] == req_w[0]) && (rdata.words[1] == req_w[1]);
      end
      cpdt_pkg::OP_VEC4: begin
        hit = (rdata.kind == cpdt_pkg::KIND_IMMEDIATE) && (rdata.words == req_w);
      end
      cpdt_pkg::OP_SCALAR: begin
        hit = (rdata.kind == cpdt_pkg::KIND_IMMEDIATE) && (|comp_eq);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    hit = hit && pend_valid;
    if (op != cpdt_pkg::OP_SCALAR) begin
      hit_comp = 2'd0;
    end
  end

  assign st.hit       = hit;
  assign st.scan_done = is_clear || (!pend_valid && (rd_addr == count));

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = count[IW-1:0];
    wr_row     = free_row;
    count_next = count;
    res_idx    = '0;
    res_comp   = 2'd0;
    res_found  = 1'b0;
    res_full   = 1'b0;
    if (found) begin
      res_idx   = found_idx;
      res_comp  = found_comp;
      res_found = 1'b1;
    end else if (is_clear) begin
      count_next = '0;
    end else if (op == cpdt_pkg::OP_SCALAR && free_valid) begin
      wr_en                         = 1'b1;
      wr_addr                       = free_idx;
      wr_row.words[free_row.used[1:0]] = req_w[0];
      wr_row.used                   = free_row.used + 3'd1;
      res_idx                       = free_idx;
      res_comp                      = free_row.used[1:0];
    end else if (count == CW'(DEPTH)) begin
      res_full = 1'b1;
    end else begin
      wr_en       = 1'b1;
      wr_row.kind = (op == cpdt_pkg::OP_STATE) ? cpdt_pkg::KIND_STATE
                                               : cpdt_pkg::KIND_IMMEDIATE;
      if (op == cpdt_pkg::OP_SCALAR) begin
        wr_row.used  = 3'd1;
        wr_row.words = '0;
        wr_row.words[0] = req_w[0];
      end else begin
        wr_row.used  = cpdt_pkg::FULL_SIZE;
        wr_row.words = req_w;
      end
      res_idx    = count[IW-1:0];
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rdata <= mem[rd_addr[IW-1:0]];
    end
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      free_valid <= 1'b0;
    end else if (cmd.load) begin
      op         <= cpdt_pkg::op_t'(s_tuser);
      rd_addr    <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      free_valid <= 1'b0;
      if (cpdt_pkg::op_t'(s_tuser) == cpdt_pkg::OP_STATE) begin
        req_w <= {64'h0, s_tdata[63:32], s_tdata[31:0]};
      end else begin
        req_w <= s_tdata[191:64];
      end
    end else if (cmd.scan) begin
      if (rd_addr < count) begin
        rd_addr    <= rd_addr + CW'(1);
        pend_valid <= 1'b1;
        pend_idx   <= rd_addr[IW-1:0];
      end else begin
        pend_valid <= 1'b0;
      end
      if (hit) begin
        found      <= 1'b1;
        found_idx  <= pend_idx;
        found_comp <= hit_comp;
      end else if (pend_valid && rdata.kind == cpdt_pkg::KIND_IMMEDIATE &&
                   rdata.used < cpdt_pkg::FULL_SIZE) begin
        free_valid <= 1'b1;
        free_idx   <= pend_idx;
        free_row   <= rdata;
      end
    end else if (cmd.commit) begin
      count      <= count_next;
      pend_valid <= 1'b0;
      m_tdata    <= {6'h0, res_full, res_found, res_comp,
                     cpdt_pkg::OUT_IDX_W'(res_idx)};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_pend_in_range: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (CW'(pend_idx) < count))
    else $error("compare of an entry beyond the count");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (!found && !free_valid && !pend_valid))
    else $error("scan state not cleared on a new beat");

endmodule
